// File: rtl/core/sibd_pkg.sv
// ----------------------------------------------------------------------------
// sibd_pkg
// Shared types and constants for the signed integer to base digits block.
// ----------------------------------------------------------------------------
`default_nettype none

package sibd_pkg;

    localparam logic [7:0] SIGN_PLUS  = 8'h2B;
    localparam logic [7:0] SIGN_MINUS = 8'h2D;

    // register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_ALPHABET_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHABET_HIGH = 2'd1;
    localparam logic [1:0] REG_RADIX_LENGTH  = 2'd2;

    localparam int MAX_DIGITS  = 32;
    localparam int BITS_PER_CY = 8;   // quotient bits resolved per divide cycle
    localparam logic [1:0] DIV_LAST_STEP = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic check_en;
        logic div_en;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic chk_last;
        logic alpha_bad;
        logic div_done;
        logic quot_zero;
        logic digits_full;
        logic neg;
        logic one_left;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/sibd_regs.sv
// ----------------------------------------------------------------------------
// sibd_regs
// APB register file: alphabet words and radix length.
// ----------------------------------------------------------------------------
`default_nettype none

module sibd_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output logic      [127:0] alphabet,
    output logic      [4:0]  radix
);

    logic [63:0] alpha_low_reg;
    logic [63:0] alpha_high_reg;
    logic [4:0]  radix_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:3])
                sibd_pkg::REG_ALPHABET_LOW:  alpha_low_reg  <= pwdata;
                sibd_pkg::REG_ALPHABET_HIGH: alpha_high_reg <= pwdata;
                sibd_pkg::REG_RADIX_LENGTH:  radix_reg      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            sibd_pkg::REG_ALPHABET_LOW:  prdata = alpha_low_reg;
            sibd_pkg::REG_ALPHABET_HIGH: prdata = alpha_high_reg;
            sibd_pkg::REG_RADIX_LENGTH:  prdata = {59'd0, radix_reg};
            default:                     prdata = '0;
        endcase
    end

    assign alphabet = {alpha_high_reg, alpha_low_reg};
    assign radix    = radix_reg;

endmodule

`default_nettype wire

// File: rtl/core/sibd_ctrl.sv
// ----------------------------------------------------------------------------
// sibd_ctrl
// Sequencer: alphabet check, digit extraction, character output.
// ----------------------------------------------------------------------------
`default_nettype none

module sibd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sibd_pkg::status_t status,
    output sibd_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   strobe
);

    sibd_pkg::state_t state_reg;
    sibd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sibd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sibd_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = sibd_pkg::ST_CHECK;
            end
            sibd_pkg::ST_CHECK:
            begin
                if (status.chk_last)
                    state_next = status.alpha_bad ? sibd_pkg::ST_IDLE : sibd_pkg::ST_DIVIDE;
            end
            sibd_pkg::ST_DIVIDE:
            begin
                if (status.div_done && (status.quot_zero || status.digits_full))
                    state_next = status.neg ? sibd_pkg::ST_SIGN : sibd_pkg::ST_EMIT;
            end
            sibd_pkg::ST_SIGN:
                state_next = sibd_pkg::ST_EMIT;
            sibd_pkg::ST_EMIT:
            begin
                if (status.one_left)
                    state_next = sibd_pkg::ST_IDLE;
            end
            default:
                state_next = sibd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd    = '0;
        busy   = 1'b1;
        strobe = 1'b0;
        case (state_reg)
            sibd_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            sibd_pkg::ST_CHECK:
                cmd.check_en = 1'b1;
            sibd_pkg::ST_DIVIDE:
                cmd.div_en = 1'b1;
            sibd_pkg::ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                strobe        = 1'b1;
            end
            sibd_pkg::ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                strobe         = 1'b1;
            end
            default:
                busy = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/sibd_dp.sv
// ----------------------------------------------------------------------------
// sibd_dp
// Datapath: alphabet checker, radix divider, digit stack and symbol lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sibd_dp #(
    parameter int MAX_BASE = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [127:0]      alphabet,
    input  wire logic [4:0]        radix,
    input  wire logic signed [31:0] value,
    input  wire sibd_pkg::cmd_t    cmd,
    output sibd_pkg::status_t      status,
    output logic      [7:0]        symbol,
    output logic                   last_symbol
);

    localparam int CW = $clog2(MAX_BASE);
    localparam int ND = $clog2(sibd_pkg::MAX_DIGITS + 1);

    logic [7:0] sym [MAX_BASE];

    logic [CW-1:0] ck_reg;
    logic          bad_reg;
    logic [1:0]    step_reg;
    logic [ND-1:0] nd_reg;
    logic          neg_reg;
    logic [31:0]   quot_reg;
    logic [CW:0]   rem_reg;
    logic [sibd_pkg::MAX_DIGITS-1:0][CW-1:0] stack_reg;

    logic [7:0]  sel_sym;
    logic        ck_in_use;
    logic        dup;
    logic        bad_now;
    logic        range_bad;
    logic [31:0] qv;
    logic [CW:0] rv;
    logic [CW:0] radix_cut;

    always_comb
    begin
        for (int i = 0; i < MAX_BASE; i++)
            sym[i] = alphabet[8*i +: 8];
    end

    // one symbol a cycle against every later symbol in use, and against NUL, '+' and '-'
    always_comb
    begin
        sel_sym   = sym[ck_reg];
        ck_in_use = 5'(ck_reg) < radix;
        dup       = 1'b0;
        for (int j = 0; j < MAX_BASE; j++)
        begin
            if ((CW'(j) > ck_reg) && (5'(j) < radix) && (sym[j] == sel_sym))
                dup = 1'b1;
        end
        bad_now   = ck_in_use && ((sel_sym == 8'd0) || (sel_sym == sibd_pkg::SIGN_PLUS)
                    || (sel_sym == sibd_pkg::SIGN_MINUS) || dup);
        range_bad = (radix < 5'd2) || (radix > 5'(MAX_BASE));
    end

    // restoring division, eight quotient bits per cycle
    always_comb
    begin
        radix_cut = radix[CW:0];
        qv        = quot_reg;
        rv        = (step_reg == 2'd0) ? '0 : rem_reg;
        for (int k = 0; k < sibd_pkg::BITS_PER_CY; k++)
        begin
            rv = {rv[CW-1:0], qv[31]};
            qv = {qv[30:0], 1'b0};
            if (rv >= radix_cut)
            begin
                rv    = rv - radix_cut;
                qv[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ck_reg   <= '0;
            bad_reg  <= 1'b0;
            step_reg <= '0;
            nd_reg   <= '0;
            neg_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            ck_reg   <= '0;
            bad_reg  <= 1'b0;
            step_reg <= '0;
            nd_reg   <= '0;
            neg_reg  <= value[31];
        end
        else if (cmd.check_en)
        begin
            ck_reg  <= ck_reg + 1'b1;
            bad_reg <= bad_reg | bad_now;
        end
        else if (cmd.div_en)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == sibd_pkg::DIV_LAST_STEP)
                nd_reg <= nd_reg + 1'b1;
        end
        else if (cmd.emit_digit)
        begin
            nd_reg <= nd_reg - 1'b1;
        end
    end

    // newest digit at the bottom: the most significant one comes out first
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            quot_reg <= value[31] ? (32'd0 - 32'(value)) : 32'(value);
        else if (cmd.div_en)
        begin
            quot_reg <= qv;
            rem_reg  <= rv;
            if (step_reg == sibd_pkg::DIV_LAST_STEP)
                stack_reg <= {stack_reg[sibd_pkg::MAX_DIGITS-2:0], rv[CW-1:0]};
        end
        else if (cmd.emit_digit)
            stack_reg <= {{CW{1'b0}}, stack_reg[sibd_pkg::MAX_DIGITS-1:1]};
    end

    always_comb
    begin
        status.chk_last    = (ck_reg == CW'(MAX_BASE - 1));
        status.alpha_bad   = bad_reg | bad_now | range_bad;
        status.div_done    = (step_reg == sibd_pkg::DIV_LAST_STEP);
        status.quot_zero   = (qv == 32'd0);
        status.digits_full = (nd_reg == ND'(sibd_pkg::MAX_DIGITS - 1));
        status.neg         = neg_reg;
        status.one_left    = (nd_reg == ND'(1));
    end

    assign symbol      = cmd.emit_sign ? sibd_pkg::SIGN_MINUS : sym[stack_reg[0]];
    assign last_symbol = cmd.emit_digit && (nd_reg == ND'(1));

endmodule

`default_nettype wire

// File: rtl/core/signed_integer_to_base_digits.sv
// ----------------------------------------------------------------------------
// signed_integer_to_base_digits
// Writes a signed 32-bit value out as characters of a configured alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Program alphabet_low (0x00), alphabet_high (0x08) and radix_length (0x10)
//   over the APB port while the block is idle. A value is transferred when
//   start is high and busy is low. Characters appear on symbol, each for one
//   cycle with strobe high; last_symbol marks the final one. A negative value
//   gives a leading '-'. An invalid alphabet gives no characters at all.
// Sequence:
//   The transfer is accepted, then the alphabet is checked (one symbol compared
//   against every later symbol in use per cycle), then the divider extracts
//   the digits (8 quotient bits per cycle), then the characters are shown in turn.
//   busy stays high until the last character has gone.
// Reset clears the APB registers to zero (an invalid alphabet) and the
// sequencer to idle. The receiver cannot stall: each character is taken in
// the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_base_digits #(
    parameter int MAX_BASE = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] value,
    output logic                    strobe,
    output logic      [7:0]         symbol,
    output logic                    last_symbol,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready
);

    logic [127:0]      alphabet;
    logic [4:0]        radix;
    sibd_pkg::cmd_t    cmd;
    sibd_pkg::status_t status;

    sibd_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .alphabet (alphabet),
        .radix    (radix)
    );

    sibd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    sibd_dp #(
        .MAX_BASE (MAX_BASE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .alphabet    (alphabet),
        .radix       (radix),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .symbol      (symbol),
        .last_symbol (last_symbol)
    );

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character strobe outside a conversion");

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_symbol |-> strobe)
        else $error("last marker without a character");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_symbol) |=> !busy)
        else $error("still busy after the final character");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("transfer did not start a conversion");
`endif

endmodule

`default_nettype wire
